// ----- hw/rtl/a64mov_pkg.sv -----
// Shared constants and types for the 64-bit constant materializer.
`timescale 1ns / 1ps

package a64mov_pkg;

    // Opcode bases of the wide-move and logical-immediate forms
    localparam logic [31:0] OP_MOVZ = 32'hD280_0000;
    localparam logic [31:0] OP_MOVN = 32'h9280_0000;
    localparam logic [31:0] OP_MOVK = 32'hF280_0000;
    localparam logic [31:0] OP_ORRI = 32'hB200_0000;
    // Bits that tell the wide-move opcodes apart
    localparam logic [31:0] OP_WIDE_MASK = 32'hFF80_0000;

    localparam int unsigned MAX_WORDS = 4;
    localparam int unsigned IDX_W     = $clog2(MAX_WORDS);

    // One decoded constant: the words in emission order and the index of the final one
    typedef struct packed {
        logic [MAX_WORDS-1:0][31:0] words;
        logic [IDX_W-1:0]           last_idx;
    } t_seq;

endpackage

// ----- hw/rtl/aarch64_mov64_immediate_encoder_core.sv -----
// Top level of the 64-bit constant materializer.
`timescale 1ns / 1ps

// Turns (register, 64-bit constant) into the AArch64 words that load it: one MOVZ,
// MOVN or ORR-immediate word, or a MOVK run (high chunk first) ending in MOVZ/MOVN;
// o_last marks the final word. The front end is a five-stage pipeline that accepts a
// constant every cycle while not full; a two-entry queue feeds the emitter, which
// gives one word per cycle while its output is empty or popped, so a constant
// yields 1 to 4 words, and that word count sets the sustained rate.
module aarch64_mov64_immediate_encoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [4:0]  i_dest_reg,
    input  logic [63:0] i_value,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_instr_word,
    output logic        o_last
);

    logic             f_valid, f_ready;
    a64mov_pkg::t_seq f_seq;
    logic             q_valid, q_pop;
    a64mov_pkg::t_seq q_seq;

    a64mov_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_dest_reg  (i_dest_reg),
        .i_value     (i_value),
        .o_seq_valid (f_valid),
        .i_seq_ready (f_ready),
        .o_seq       (f_seq)
    );

    a64mov_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_seq   (f_seq),
        .o_rd_valid (q_valid),
        .i_rd_pop   (q_pop),
        .o_rd_seq   (q_seq)
    );

    a64mov_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seq_valid  (q_valid),
        .i_seq        (q_seq),
        .o_seq_pop    (q_pop),
        .empty        (empty),
        .pop          (pop),
        .o_instr_word (o_instr_word),
        .o_last       (o_last)
    );

`ifndef SYNTHESIS
    // nothing to show right after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown after reset");

    // every word before the final one of a sequence is a MOVK
    a_mid_movk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last) |->
            ((o_instr_word & a64mov_pkg::OP_WIDE_MASK) == a64mov_pkg::OP_MOVK))
        else $error("non-final word is not a MOVK");

    // a sequence never ends on a MOVK
    a_last_not_movk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last) |->
            ((o_instr_word & a64mov_pkg::OP_WIDE_MASK) != a64mov_pkg::OP_MOVK))
        else $error("final word is a MOVK");

    // queue only moves a sequence to the emitter when one is waiting
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("sequence popped from empty queue");
`endif

endmodule

// ----- hw/rtl/a64mov_front.sv -----
// Front end: accepts constants, finds the bitmask encoding and builds the word sequence.
`timescale 1ns / 1ps

module a64mov_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [4:0]           i_dest_reg,
    input  logic [63:0]          i_value,
    output logic                 o_seq_valid,
    input  logic                 i_seq_ready,
    output a64mov_pkg::t_seq     o_seq
);

    localparam int unsigned NSTG = 5;

    typedef struct packed {
        logic [4:0]  rd;
        logic [63:0] value;
        logic [63:0] clr;     // value with its trailing ones cleared
        logic [2:0]  nz;      // chunks that are nonzero
        logic [2:0]  nf;      // chunks other than all ones
        logic [1:0]  fz;
        logic [1:0]  fn;
        logic [6:0]  rot;
        logic [63:0] norm;
        logic [6:0]  zeros;
        logic [6:0]  ones;
    } t_cls;

    function automatic logic [6:0] tz64(input logic [63:0] v);
        logic [6:0]  n;
        logic [63:0] x;
        n = 7'd0;
        x = v;
        if (x[31:0] == 32'd0) begin n = n | 7'd32; x = x >> 32; end
        if (x[15:0] == 16'd0) begin n = n | 7'd16; x = x >> 16; end
        if (x[7:0] == 8'd0)   begin n = n | 7'd8;  x = x >> 8;  end
        if (x[3:0] == 4'd0)   begin n = n | 7'd4;  x = x >> 4;  end
        if (x[1:0] == 2'd0)   begin n = n | 7'd2;  x = x >> 2;  end
        if (x[0] == 1'b0)     begin n = n | 7'd1;  x = x >> 1;  end
        if (v == 64'd0) begin
            n = 7'd64;
        end
        return n;
    endfunction

    function automatic logic [6:0] lz64(input logic [63:0] v);
        logic [63:0] r;
        r = {<<{v}};
        return tz64(r);
    endfunction

    function automatic logic [63:0] rotr64(input logic [63:0] v, input logic [5:0] r);
        logic [63:0] res;
        if (r == 6'd0) begin
            res = v;
        end else begin
            res = (v >> r) | (v << (7'd64 - {1'b0, r}));
        end
        return res;
    endfunction

    function automatic logic [31:0] wide_op(input logic [31:0] base, input logic [4:0] rd,
                                            input logic [15:0] imm, input logic [1:0] hw);
        return base | {9'd0, hw, imm, rd};
    endfunction

    function automatic a64mov_pkg::t_seq build(input t_cls s);
        a64mov_pkg::t_seq             q;
        logic [3:0][15:0]             ch;
        logic [6:0]                   size;
        logic                         bm_ok;
        logic [5:0]                   immr;
        logic [5:0]                   imms;
        logic                         zform;
        logic [1:0]                   lead;
        logic [a64mov_pkg::IDX_W-1:0] k;
        logic                         sel;
        q    = '0;
        ch   = s.value;
        size = s.zeros + s.ones;
        bm_ok = (size != 7'd0) && (rotr64(s.value, size[5:0]) == s.value)
                && ((size & (size - 7'd1)) == 7'd0)
                && (s.value != 64'd0) && (s.value != '1);
        immr = (6'd0 - s.rot[5:0]) & ((size == 7'd64) ? 6'h3F : 6'(size - 7'd1));
        imms = (6'd0 - {size[4:0], 1'b0}) | 6'(s.ones - 7'd1);
        zform = ({1'b0, s.nz} <= (4'd1 + {1'b0, s.nf}));
        lead  = zform ? s.fz : s.fn;
        k     = '0;
        if (s.nz <= 3'd1) begin
            q.words[0] = wide_op(a64mov_pkg::OP_MOVZ, s.rd, ch[s.fz], s.fz);
        end else if (s.nf <= 3'd1) begin
            q.words[0] = wide_op(a64mov_pkg::OP_MOVN, s.rd, ~ch[s.fn], s.fn);
        end else if (bm_ok) begin
            q.words[0] = a64mov_pkg::OP_ORRI | {9'd0, size[6], immr, imms, 5'd31, s.rd};
        end else begin
            // MOVKs from the high chunk down, then the lead move
            for (int i = 3; i >= 0; i--) begin
                sel = zform ? (ch[i] != 16'd0) : (ch[i] != 16'hFFFF);
                if ((2'(i) != lead) && sel) begin
                    q.words[k] = wide_op(a64mov_pkg::OP_MOVK, s.rd, ch[i], 2'(i));
                    k = k + 1'b1;
                end
            end
            q.words[k] = zform ? wide_op(a64mov_pkg::OP_MOVZ, s.rd, ch[lead], lead)
                               : wide_op(a64mov_pkg::OP_MOVN, s.rd, ~ch[lead], lead);
            q.last_idx = k;
        end
        return q;
    endfunction

    logic [NSTG-1:0] r_v, n_v;
    t_cls            r_s [NSTG];
    t_cls            n_s [NSTG];
    logic [NSTG-1:0] go;
    logic            accept;
    t_cls            in_cls;

    always_comb begin
        go[NSTG-1] = r_v[NSTG-1] && i_seq_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            go[k] = r_v[k] && (!r_v[k+1] || go[k+1]);
        end
    end

    assign full   = r_v[0] && !go[0];
    assign accept = push && !full;

    // Chunk census and trailing-ones clear on the way in
    always_comb begin
        logic f_z;
        logic f_n;
        logic [15:0] c;
        in_cls       = '0;
        in_cls.rd    = i_dest_reg;
        in_cls.value = i_value;
        in_cls.clr   = i_value & (i_value + 64'd1);
        f_z = 1'b0;
        f_n = 1'b0;
        for (int i = 0; i < 4; i++) begin
            c = i_value[16*i +: 16];
            if (c != 16'd0) begin
                in_cls.nz = in_cls.nz + 3'd1;
                if (!f_z) begin in_cls.fz = 2'(i); f_z = 1'b1; end
            end
            if (c != 16'hFFFF) begin
                in_cls.nf = in_cls.nf + 3'd1;
                if (!f_n) begin in_cls.fn = 2'(i); f_n = 1'b1; end
            end
        end
    end

    always_comb begin
        n_s[0] = in_cls;
        n_s[1] = r_s[0];
        n_s[1].rot = tz64(r_s[0].clr);
        n_s[2] = r_s[1];
        n_s[2].norm = rotr64(r_s[1].value, r_s[1].rot[5:0]);
        n_s[3] = r_s[2];
        n_s[3].zeros = lz64(r_s[2].norm);
        n_s[3].ones  = tz64(~r_s[2].norm);
        n_s[4] = r_s[3];
    end

    always_comb begin
        n_v[0] = accept ? 1'b1 : (go[0] ? 1'b0 : r_v[0]);
        for (int k = 1; k < NSTG; k++) begin
            n_v[k] = go[k-1] ? 1'b1 : (go[k] ? 1'b0 : r_v[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s[0] <= n_s[0];
        end
        for (int k = 1; k < NSTG; k++) begin
            if (go[k-1]) begin
                r_s[k] <= n_s[k];
            end
        end
    end

    assign o_seq_valid = r_v[NSTG-1];
    assign o_seq       = build(r_s[NSTG-1]);

endmodule

// ----- hw/rtl/a64mov_queue.sv -----
// Two-entry queue of word sequences between the front end and the emitter.
`timescale 1ns / 1ps

module a64mov_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  a64mov_pkg::t_seq i_wr_seq,
    output logic             o_rd_valid,
    input  logic             i_rd_pop,
    output a64mov_pkg::t_seq o_rd_seq
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    a64mov_pkg::t_seq r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             wr, rd;

    assign o_wr_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign wr         = i_wr_valid && o_wr_ready;
    assign rd         = i_rd_pop && o_rd_valid;
    assign o_rd_seq   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_wr_seq;
        end
    end

endmodule

// ----- hw/rtl/a64mov_back.sv -----
// Emitter: one head-sequence word per cycle, unless held, into the output reg.
`timescale 1ns / 1ps

module a64mov_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_seq_valid,
    input  a64mov_pkg::t_seq i_seq,
    output logic             o_seq_pop,
    output logic             empty,
    input  logic             pop,
    output logic [31:0]      o_instr_word,
    output logic             o_last
);

    logic [a64mov_pkg::IDX_W-1:0] r_idx, n_idx;
    logic                         r_out_valid, n_out_valid;
    logic [31:0]                  r_word;
    logic                         r_last;
    logic                         take, at_last;

    assign take      = i_seq_valid && (!r_out_valid || pop);
    assign at_last   = (r_idx == i_seq.last_idx);
    assign o_seq_pop = take && at_last;

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (take) begin
            n_idx       = at_last ? '0 : r_idx + 1'b1;
            n_out_valid = 1'b1;
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_word <= i_seq.words[r_idx];
            r_last <= at_last;
        end
    end

    assign empty        = !r_out_valid;
    assign o_instr_word = r_word;
    assign o_last       = r_last;

endmodule

// ----- verif/mov64_word_checker.sv -----
// Checker for the constant materializer: predicts the instruction words and compares them.
`timescale 1ns / 1ps

module mov64_word_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [4:0]  i_dest_reg,
    input  logic [63:0] i_value,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [31:0] i_instr_word,
    input  logic        i_last,
    output int          o_mismatches,
    output int          o_words_owed
);

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_owed_word;

    t_owed_word owed_words[$];
    int         mismatch_cnt = 0;

    assign o_mismatches = mismatch_cnt;

    function automatic int unsigned trailing_zeros(input logic [63:0] v);
        int unsigned n;
        n = 0;
        while (n < 64 && v[n] == 1'b0) n++;
        return n;
    endfunction

    function automatic int unsigned leading_zeros(input logic [63:0] v);
        int unsigned n;
        n = 0;
        while (n < 64 && v[63-n] == 1'b0) n++;
        return n;
    endfunction

    function automatic logic [63:0] rotate_right(input logic [63:0] v, input int unsigned r);
        int unsigned amt;
        amt = r & 63;
        if (amt == 0) return v;
        return (v >> amt) | (v << (64 - amt));
    endfunction

    // Bit 13 flags a valid logical immediate; below it sit N, immr, imms
    function automatic logic [13:0] logic_imm_field(input logic [63:0] v);
        int unsigned rot;
        int unsigned zeros;
        int unsigned ones;
        int unsigned size;
        logic [63:0] norm;
        logic [63:0] rot64;
        logic [63:0] size64;
        logic [63:0] ones64;
        logic [63:0] immr;
        logic [63:0] imms;
        if (v == 64'd0 || v == {64{1'b1}}) return '0;
        rot    = trailing_zeros(v & (v + 64'd1));
        norm   = rotate_right(v, rot);
        zeros  = leading_zeros(norm);
        ones   = trailing_zeros(~norm);
        size   = zeros + ones;
        if (size == 0 || size > 64) return '0;
        if (rotate_right(v, size) != v) return '0;
        if ((size & (size - 1)) != 0) return '0;
        rot64  = rot;
        size64 = size;
        ones64 = ones;
        immr   = (64'd0 - rot64) & ((size == 64) ? 64'd63 : size64 - 64'd1) & 64'h3F;
        imms   = ((64'd0 - size64 * 64'd2) | (ones64 - 64'd1)) & 64'h3F;
        return {1'b1, size64[6], immr[5:0], imms[5:0]};
    endfunction

    function automatic logic [31:0] wide_word(input logic [31:0] base, input logic [4:0] rd,
                                              input logic [15:0] imm, input int hw);
        logic [31:0] hw32;
        hw32 = hw & 3;
        return base | (hw32 << 21) | ({16'd0, imm} << 5) | {27'd0, rd};
    endfunction

    function automatic void owe_word(input logic [31:0] word, input logic last);
        t_owed_word w;
        w.word = word;
        w.last = last;
        owed_words.push_back(w);
    endfunction

    function automatic void encode_constant(input logic [4:0] rd, input logic [63:0] v);
        logic [15:0] ch [4];
        logic [15:0] inv [4];
        logic [13:0] field;
        int nz;
        int nf;
        int fz;
        int fn;
        nz = 0;
        nf = 0;
        fz = -1;
        fn = -1;
        for (int i = 0; i < 4; i++) begin
            ch[i]  = v[16*i +: 16];
            inv[i] = ~ch[i];
            if (ch[i] != 16'd0) begin
                nz++;
                if (fz < 0) fz = i;
            end
            if (inv[i] != 16'd0) begin
                nf++;
                if (fn < 0) fn = i;
            end
        end
        if (nz <= 1) begin
            owe_word(wide_word(a64mov_pkg::OP_MOVZ, rd, (fz < 0) ? 16'd0 : ch[fz],
                               (fz < 0) ? 0 : fz), 1'b1);
            return;
        end
        if (nf <= 1) begin
            owe_word(wide_word(a64mov_pkg::OP_MOVN, rd, (fn < 0) ? 16'd0 : inv[fn],
                               (fn < 0) ? 0 : fn), 1'b1);
            return;
        end
        field = logic_imm_field(v);
        if (field[13]) begin
            owe_word(a64mov_pkg::OP_ORRI | ({31'd0, field[12]} << 22)
                     | ({26'd0, field[11:6]} << 16)
                     | ({26'd0, field[5:0]} << 10) | (32'd31 << 5) | {27'd0, rd}, 1'b1);
            return;
        end
        if (nz <= 1 + nf) begin
            for (int i = 3; i >= 0; i--)
                if (i != fz && ch[i] != 16'd0)
                    owe_word(wide_word(a64mov_pkg::OP_MOVK, rd, ch[i], i), 1'b0);
            owe_word(wide_word(a64mov_pkg::OP_MOVZ, rd, ch[fz], fz), 1'b1);
        end else begin
            // MOVKs after a MOVN still insert the true chunk
            for (int i = 3; i >= 0; i--)
                if (i != fn && inv[i] != 16'd0)
                    owe_word(wide_word(a64mov_pkg::OP_MOVK, rd, ch[i], i), 1'b0);
            owe_word(wide_word(a64mov_pkg::OP_MOVN, rd, inv[fn], fn), 1'b1);
        end
    endfunction

    always @(posedge i_clk) begin
        t_owed_word exp_w;
        if (i_rst_n) begin
            if (i_push && !i_full) encode_constant(i_dest_reg, i_value);
            if (i_pop && !i_empty) begin
                if (owed_words.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: unexpected word %h last %b", $realtime, i_instr_word,
                                 i_last);
                end else begin
                    exp_w = owed_words.pop_front();
                    if (i_instr_word !== exp_w.word) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("%0t: instr_word expected %h got %h", $realtime,
                                     exp_w.word, i_instr_word);
                    end
                    if (i_last !== exp_w.last) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("%0t: last expected %b got %b (word %h)", $realtime,
                                     exp_w.last, i_last, exp_w.word);
                    end
                end
            end
            o_words_owed <= owed_words.size();
        end
    end

endmodule

// ----- verif/aarch64_mov64_immediate_encoder_core_tb.sv -----
// Testbench top for the constant materializer: stimulus, result-side stalls and verdict.
`timescale 1ns / 1ps

module aarch64_mov64_immediate_encoder_core_tb;

    localparam int RANDOM_ITEMS = 480;
    localparam int CYCLE_LIMIT  = 200000;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        push         = 1'b0;
    logic        pop          = 1'b0;
    logic [4:0]  i_dest_reg   = 5'd0;
    logic [63:0] i_value      = 64'd0;
    logic        steady       = 1'b0;
    logic        full;
    logic        empty;
    logic [31:0] o_instr_word;
    logic        o_last;
    int          mismatches;
    int          words_owed;
    int          cycle_cnt    = 0;

    aarch64_mov64_immediate_encoder_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_dest_reg   (i_dest_reg),
        .i_value      (i_value),
        .empty        (empty),
        .pop          (pop),
        .o_instr_word (o_instr_word),
        .o_last       (o_last)
    );

    mov64_word_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_dest_reg   (i_dest_reg),
        .i_value      (i_value),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_instr_word (o_instr_word),
        .i_last       (o_last),
        .o_mismatches (mismatches),
        .o_words_owed (words_owed)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= steady ? 1'b1 : ($urandom_range(0, 99) >= 27);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // {register, constant}: zero, all ones, single chunks, single non-FFFF chunks,
    // logical immediates, MOVZ/MOVN runs and the cost tie
    function automatic logic [68:0] directed_item(input int idx);
        case (idx)
            0:  return {5'd0,  64'h0000_0000_0000_0000};
            1:  return {5'd30, 64'hFFFF_FFFF_FFFF_FFFF};
            2:  return {5'd31, 64'h0000_0000_0000_BEEF};
            3:  return {5'd5,  64'h0000_0000_1234_0000};
            4:  return {5'd7,  64'h0000_ABCD_0000_0000};
            5:  return {5'd9,  64'hFFFF_0000_0000_0000};
            6:  return {5'd11, 64'hFFFF_FFFF_FFFF_0000};
            7:  return {5'd12, 64'hFFFF_FFFF_1234_FFFF};
            8:  return {5'd13, 64'h0000_FFFF_FFFF_FFFF};
            9:  return {5'd14, 64'h5555_5555_5555_5555};
            10: return {5'd15, 64'h0000_0000_FFFF_FFFF};
            11: return {5'd16, 64'h00FF_00FF_00FF_00FF};
            12: return {5'd17, 64'h8000_0000_0000_0001};
            13: return {5'd18, 64'h1234_5678_9ABC_DEF0};
            14: return {5'd19, 64'hFFFF_1234_FFFF_5678};
            15: return {5'd20, 64'h1234_FFFF_5678_0000};
            16: return {5'd21, 64'h0001_0000_0000_0001};
            17: return {5'd22, 64'hFFFE_FFFF_FFFF_FFFE};
            18: return {5'd1,  64'h7FFF_FFFF_FFFF_FFFF};
            19: return {5'd2,  64'h0000_0001_0000_0000};
            20: return {5'd31, 64'hAAAA_AAAA_AAAA_AAAA};
            default: return {5'd31, 64'hFFFF_FFFF_FFFF_FFFF};
        endcase
    endfunction

    // replicated, rotated run of ones
    function automatic logic [63:0] logic_imm_value();
        int unsigned esize;
        int unsigned ones;
        int unsigned r;
        logic [63:0] mask;
        logic [63:0] elem;
        logic [63:0] v;
        esize = 2 << $urandom_range(0, 5);
        ones  = $urandom_range(1, esize - 1);
        r     = $urandom_range(0, esize - 1);
        mask  = (esize == 64) ? {64{1'b1}} : ((64'd1 << esize) - 64'd1);
        elem  = (64'd1 << ones) - 64'd1;
        if (r != 0) elem = ((elem >> r) | (elem << (esize - r))) & mask;
        v = 64'd0;
        for (int i = 0; i < 64; i += esize) v = v | (elem << i);
        return v;
    endfunction

    function automatic logic [63:0] next_constant();
        int unsigned pick;
        int unsigned k;
        logic [63:0] v;
        pick = $urandom_range(0, 99);
        v = {$urandom(), $urandom()};
        if (pick < 20) begin
            v = logic_imm_value();
        end else if (pick < 70) begin
            for (int i = 0; i < 4; i++) begin
                k = $urandom_range(0, 9);
                if (k < 3)      v[16*i +: 16] = 16'h0000;
                else if (k < 6) v[16*i +: 16] = 16'hFFFF;
            end
        end else if (pick < 78) begin
            k = $urandom_range(0, 3);
            v = 64'd0;
            v[16*k +: 16] = 16'($urandom());
        end else if (pick < 85) begin
            k = $urandom_range(0, 3);
            v = {64{1'b1}};
            v[16*k +: 16] = 16'($urandom());
        end
        return v;
    endfunction

    task automatic send_constant(input logic [4:0] rd, input logic [63:0] v);
        while (!steady && $urandom_range(0, 99) < 27) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        i_dest_reg <= rd;
        i_value    <= v;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (words_owed != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [68:0] item;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 22; i++) begin
            item = directed_item(i);
            send_constant(item[68:64], item[63:0]);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 160) steady <= 1'b1;
            if (n == 260) steady <= 1'b0;
            if (n == 340) drain();
            send_constant(5'($urandom_range(0, 31)), next_constant());
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && words_owed == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/a64mov_pkg.sv
hw/rtl/a64mov_front.sv
hw/rtl/a64mov_queue.sv
hw/rtl/a64mov_back.sv
hw/rtl/aarch64_mov64_immediate_encoder_core.sv
verif/mov64_word_checker.sv
verif/aarch64_mov64_immediate_encoder_core_tb.sv
